[rtl/core/counter_keyed_byte_stream_cipher_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the counter keyed byte stream cipher
// Clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef COUNTER_KEYED_BYTE_STREAM_CIPHER_ASSERT_SVH
`define COUNTER_KEYED_BYTE_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication
`define CBSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CBSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cbsc_pkg.sv]
// ----------------------------------------------------------------------------
// cbsc_pkg
// Shared constants and types of the counter keyed byte stream cipher.
// ----------------------------------------------------------------------------
package cbsc_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned SeedW      = 32;

  localparam logic [7:0] WhitenByte = 8'hAB;

  localparam logic [CfgIdxW-1:0] CfgPSeed = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGSeed = CfgIdxW'(1);

  // key table read request
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr_lo;
    logic [AddrW-1:0] addr_hi;
  } kt_rd_t;

  // key table status
  typedef struct packed {
    logic busy;
    logic built;
  } kt_stat_t;

endpackage

[rtl/core/counter_keyed_byte_stream_cipher.sv]
// ----------------------------------------------------------------------------
// counter_keyed_byte_stream_cipher
// Byte stream cipher: whiten, nibble swap, XOR with two counter-indexed keys.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i/in_ready_o | mode, data_byte, last_byte
//  out     | output    | out_valid_o/out_ready_i | data_out, last_out
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
//  One word per cycle while the output is not stalled and no rebuild runs;
//  each word passes the key stage and then the output register. The key
//  table memories answer in the cycle after the counter addresses them.
//  A seed write starts a table rebuild (two multiplies in series); in_ready_o
//  is low until it finishes. After reset both tables read as zero; no rebuild
//  runs. A stalled output holds the pipeline; the config port never stalls.
// ----------------------------------------------------------------------------
module counter_keyed_byte_stream_cipher
  import cbsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SeedW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         data_out_o,
  output logic               last_out_o
);

  logic [SeedW-1:0] p_seed_q, p_seed_d, g_seed_q, g_seed_d;
  logic             cfg_wr, seed_wr;
  logic [15:0]      enc_ctr_q, dec_ctr_q, ctr;
  logic             in_acc, s1_adv;
  logic             s1_valid_q, s1_last_q;
  logic [7:0]       s1_byte_q, whitened;
  logic             out_valid_q, out_last_q;
  logic [7:0]       out_data_q;
  logic [7:0]       key_lo, key_hi;
  kt_rd_t           rd_req;
  kt_stat_t         kt_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    p_seed_d = p_seed_q;
    g_seed_d = g_seed_q;
    seed_wr  = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgPSeed: begin
          p_seed_d = cfg_data_i;
          seed_wr  = 1'b1;
        end
        CfgGSeed: begin
          g_seed_d = cfg_data_i;
          seed_wr  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_seed_q <= '0;
      g_seed_q <= '0;
    end else begin
      p_seed_q <= p_seed_d;
      g_seed_q <= g_seed_d;
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !kt_stat.busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  assign ctr            = mode_i ? dec_ctr_q : enc_ctr_q;
  assign rd_req.en      = in_acc;
  assign rd_req.addr_lo = ctr[7:0];
  assign rd_req.addr_hi = ctr[15:8];

  cbsc_keytab u_keytab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (seed_wr),
    .p_seed_i   (p_seed_d),
    .g_seed_i   (g_seed_d),
    .rd_i       (rd_req),
    .rdata_lo_o (key_lo),
    .rdata_hi_o (key_hi),
    .stat_o     (kt_stat)
  );

  // advance the counter of the selected direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_ctr_q <= '0;
      dec_ctr_q <= '0;
    end else if (in_acc) begin
      if (mode_i) begin
        dec_ctr_q <= dec_ctr_q + 16'd1;
      end else begin
        enc_ctr_q <= enc_ctr_q + 16'd1;
      end
    end
  end

  assign whitened = data_byte_i ^ WhitenByte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= {whitened[3:0], whitened[7:4]};
      s1_last_q <= last_byte_i;
    end
    if (s1_adv) begin
      out_data_q <= s1_byte_q ^ key_lo ^ key_hi;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign last_out_o  = out_last_q;

  `include "counter_keyed_byte_stream_cipher_assert.svh"

  `CBSC_ASSERT_NOW(a_no_accept_busy, in_acc, !kt_stat.busy, "word accepted during table rebuild")
  `CBSC_ASSERT_NEXT(a_seed_starts_build, seed_wr, kt_stat.busy && kt_stat.built, "seed write did not start rebuild")
  `CBSC_ASSERT_NEXT(a_accept_fills_s1, in_acc, s1_valid_q, "accepted word lost before key stage")
  `CBSC_ASSERT_NOW(a_stall_holds_s1, s1_valid_q && out_valid_q && !out_ready_i, !in_ready_o, "input taken while key stage is stalled")

endmodule

[rtl/core/cbsc_keytab.sv]
// ----------------------------------------------------------------------------
// cbsc_keytab
// Two 256 x 8 key table memories with a sweep that rebuilds both from the
// seeds, and one registered read port per table.
// ----------------------------------------------------------------------------
module cbsc_keytab
  import cbsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SeedW-1:0] p_seed_i,
  input  logic [SeedW-1:0] g_seed_i,
  input  kt_rd_t           rd_i,
  output logic [7:0]       rdata_lo_o,
  output logic [7:0]       rdata_hi_o,
  output kt_stat_t         stat_o
);

  logic [7:0] mem_lo [TableDepth];
  logic [7:0] mem_hi [TableDepth];

  logic             busy_q, busy_d;
  logic             built_q;
  logic             phase_q, phase_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [7:0]       a_q, a_d, c_q, c_d;
  logic [7:0]       ta_q, ta_d, tc_q, tc_d;
  logic [7:0]       rd_lo_q, rd_hi_q;

  logic [7:0]  a1, a2, a3, c1, c2, c3;
  logic [7:0]  sum_a, sum_c;
  logic [15:0] mul_ta, mul_tc, mul_a, mul_c;
  logic        wr_en;

  assign a1 = p_seed_i[15:8];
  assign a2 = p_seed_i[23:16];
  assign a3 = p_seed_i[31:24];
  assign c1 = g_seed_i[15:8];
  assign c2 = g_seed_i[23:16];
  assign c3 = g_seed_i[31:24];

  // first half of a step: x*b2 with x the current value, registered before the second multiply
  assign mul_ta = {8'd0, a_q} * {8'd0, a2};
  assign mul_tc = {8'd0, c_q} * {8'd0, c2};

  assign sum_a = a1 + ta_q;
  assign sum_c = c1 - tc_q;
  assign mul_a = {8'd0, sum_a} * {8'd0, a_q};
  assign mul_c = {8'd0, sum_c} * {8'd0, c_q};

  assign wr_en = busy_q && !phase_q;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    a_d     = a_q;
    c_d     = c_q;
    ta_d    = ta_q;
    tc_d    = tc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      idx_d   = '0;
      a_d     = p_seed_i[7:0];
      c_d     = g_seed_i[7:0];
    end else if (busy_q) begin
      if (!phase_q) begin
        ta_d    = mul_ta[7:0];
        tc_d    = mul_tc[7:0];
        phase_d = 1'b1;
      end else begin
        a_d     = mul_a[7:0] + a3;
        c_d     = mul_c[7:0] + c3;
        phase_d = 1'b0;
        idx_d   = idx_q + AddrW'(1);
        if (idx_q == AddrW'(TableDepth - 1)) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      built_q <= 1'b0;
      phase_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (start_i) begin
        built_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    c_q  <= c_d;
    ta_q <= ta_d;
    tc_q <= tc_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_lo[idx_q] <= a_q;
      mem_hi[idx_q] <= c_q;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_lo_q <= mem_lo[rd_i.addr_lo];
      rd_hi_q <= mem_hi[rd_i.addr_hi];
    end
  end

  // tables read as zero until the first seed write
  assign rdata_lo_o   = built_q ? rd_lo_q : 8'd0;
  assign rdata_hi_o   = built_q ? rd_hi_q : 8'd0;
  assign stat_o.busy  = busy_q;
  assign stat_o.built = built_q;

endmodule
